// ===== hw/rtl/cpf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, character codes and mod-11 helpers for the CPF validator.
// ----------------------------------------------------------------------------
package cpf_pkg;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_LENGTH    = 3'd1,
    ERR_BAD_CHAR  = 3'd2,
    ERR_SEPARATOR = 3'd3,
    ERR_REPEAT    = 3'd4,
    ERR_CHECK1    = 3'd5,
    ERR_CHECK2    = 3'd6
  } err_code_t;

  typedef struct packed {
    logic      valid_res;
    err_code_t error_code;
  } result_t;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;

  localparam logic [3:0] LEN_BARE      = 4'd11;
  localparam logic [3:0] LEN_PUNCT     = 4'd14;
  localparam logic [3:0] DIGITS_NEEDED = 4'd11;
  localparam logic [3:0] POS_DOT_A     = 4'd3;
  localparam logic [3:0] POS_DOT_B     = 4'd7;
  localparam logic [3:0] POS_DASH      = 4'd11;
  localparam logic [3:0] FIRST_DIGITS  = 4'd9;
  localparam logic [3:0] SECOND_DIGITS = 4'd10;
  localparam logic [3:0] W_FIRST       = 4'd10;
  localparam logic [3:0] W_SECOND      = 4'd11;
  localparam logic [3:0] SAME_REPEAT   = 4'd10;
  localparam logic [3:0] CNT_MAX       = 4'd15;
  localparam logic [3:0] MOD_BASE      = 4'd11;

  // residue (< 11) plus digit * weight, reduced mod 11
  function automatic logic [3:0] mod11_acc(input logic [3:0] res, input logic [3:0] v,
                                           input logic [3:0] w);
    logic [6:0] t;
    t = 7'({3'b000, res}) + 7'(7'(v) * 7'(w));
    if (t >= 7'd88) t = t - 7'd88;
    if (t >= 7'd44) t = t - 7'd44;
    if (t >= 7'd22) t = t - 7'd22;
    if (t >= 7'd11) t = t - 7'd11;
    return t[3:0];
  endfunction

  // expected check digit from a sum residue: 11 - r, or 0 when that is 10 or more
  function automatic logic [3:0] check_digit(input logic [3:0] res);
    logic [3:0] d;
    if (res <= 4'd1) begin
      d = 4'd0;
    end else begin
      d = MOD_BASE - res;
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/cpf_in_stage.sv =====
// ----------------------------------------------------------------------------
// cpf_in_stage
// Input register for the character channel; holds one request.
// ----------------------------------------------------------------------------
module cpf_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] character,
  input  logic       last,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_char,
  output logic       s1_last
);

  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_char <= character;
      s1_last <= last;
    end
  end

endmodule

// ===== hw/rtl/cpf_accum.sv =====
// ----------------------------------------------------------------------------
// cpf_accum
// Per-string counters, mod-11 sum residues and the final verdict.
// ----------------------------------------------------------------------------
module cpf_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [7:0]         ch,
  input  logic               last,
  output cpf_pkg::result_t   result
);

  logic [3:0]         char_count, char_count_next;
  logic [3:0]         digit_count, digit_count_next;
  logic [3:0]         sum_first, sum_first_next;
  logic [3:0]         sum_second, sum_second_next;
  logic [3:0]         lead_digit, lead_digit_next;
  logic [3:0]         same_count, same_count_next;
  logic [3:0]         tenth_digit, tenth_digit_next;
  cpf_pkg::err_code_t pending_error, pending_error_next;
  cpf_pkg::err_code_t note_code;
  cpf_pkg::err_code_t code;
  logic               is_digit;
  logic               note;
  logic [3:0]         v;
  logic [8:0]         last_val;

  always_comb begin
    is_digit           = (ch >= cpf_pkg::CH_ZERO) && (ch <= cpf_pkg::CH_NINE);
    v                  = ch[3:0];
    note               = 1'b0;
    note_code          = cpf_pkg::ERR_NONE;
    lead_digit_next    = lead_digit;
    same_count_next    = same_count;
    sum_first_next     = sum_first;
    sum_second_next    = sum_second;
    tenth_digit_next   = tenth_digit;
    digit_count_next   = digit_count;
    pending_error_next = pending_error;

    if (is_digit) begin
      if (digit_count == 4'd0) begin
        lead_digit_next = v;
      end else if (v == lead_digit && same_count < cpf_pkg::CNT_MAX) begin
        same_count_next = same_count + 4'd1;
      end
      if (digit_count < cpf_pkg::FIRST_DIGITS) begin
        sum_first_next = cpf_pkg::mod11_acc(sum_first, v, cpf_pkg::W_FIRST - digit_count);
      end
      if (digit_count < cpf_pkg::SECOND_DIGITS) begin
        sum_second_next = cpf_pkg::mod11_acc(sum_second, v, cpf_pkg::W_SECOND - digit_count);
      end
      if (digit_count == cpf_pkg::FIRST_DIGITS) begin
        tenth_digit_next = v;
      end
      if (digit_count < cpf_pkg::CNT_MAX) begin
        digit_count_next = digit_count + 4'd1;
      end
    end else if (ch == cpf_pkg::CH_DOT) begin
      note      = (char_count != cpf_pkg::POS_DOT_A) && (char_count != cpf_pkg::POS_DOT_B);
      note_code = cpf_pkg::ERR_SEPARATOR;
    end else if (ch == cpf_pkg::CH_DASH) begin
      note      = char_count != cpf_pkg::POS_DASH;
      note_code = cpf_pkg::ERR_SEPARATOR;
    end else begin
      note      = 1'b1;
      note_code = cpf_pkg::ERR_BAD_CHAR;
    end

    if (note && (pending_error == cpf_pkg::ERR_NONE || note_code < pending_error)) begin
      pending_error_next = note_code;
    end

    char_count_next = (char_count < cpf_pkg::CNT_MAX) ? char_count + 4'd1 : char_count;

    // final character is a digit whenever the second check is reached
    last_val = {1'b0, ch} - {1'b0, cpf_pkg::CH_ZERO};

    if (char_count_next != cpf_pkg::LEN_BARE && char_count_next != cpf_pkg::LEN_PUNCT) begin
      code = cpf_pkg::ERR_LENGTH;
    end else if (pending_error_next != cpf_pkg::ERR_NONE) begin
      code = pending_error_next;
    end else if (digit_count_next != cpf_pkg::DIGITS_NEEDED) begin
      code = cpf_pkg::ERR_SEPARATOR;
    end else if (same_count_next == cpf_pkg::SAME_REPEAT) begin
      code = cpf_pkg::ERR_REPEAT;
    end else if (cpf_pkg::check_digit(sum_first_next) != tenth_digit_next) begin
      code = cpf_pkg::ERR_CHECK1;
    end else if ({5'b0, cpf_pkg::check_digit(sum_second_next)} != last_val) begin
      code = cpf_pkg::ERR_CHECK2;
    end else begin
      code = cpf_pkg::ERR_NONE;
    end

    result.valid_res  = (code == cpf_pkg::ERR_NONE);
    result.error_code = code;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && last)) begin
      char_count    <= 4'd0;
      digit_count   <= 4'd0;
      sum_first     <= 4'd0;
      sum_second    <= 4'd0;
      lead_digit    <= 4'd0;
      same_count    <= 4'd0;
      tenth_digit   <= 4'd0;
      pending_error <= cpf_pkg::ERR_NONE;
    end else if (advance) begin
      char_count    <= char_count_next;
      digit_count   <= digit_count_next;
      sum_first     <= sum_first_next;
      sum_second    <= sum_second_next;
      lead_digit    <= lead_digit_next;
      same_count    <= same_count_next;
      tenth_digit   <= tenth_digit_next;
      pending_error <= pending_error_next;
    end
  end

endmodule

// ===== hw/rtl/cpf_out_stage.sv =====
// ----------------------------------------------------------------------------
// cpf_out_stage
// Result register for the verdict channel.
// ----------------------------------------------------------------------------
module cpf_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cpf_pkg::result_t result,
  output logic             out_free,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic             valid_res,
  output logic [2:0]       error_code
);

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      valid_res  <= result.valid_res;
      error_code <= result.error_code;
    end
  end

endmodule

// ===== hw/rtl/cpf_check_digit_validator.sv =====
// ----------------------------------------------------------------------------
// cpf_check_digit_validator
// Streams a CPF number one ASCII character per request and reports validity.
// ----------------------------------------------------------------------------
// Input channel (req_valid / req_stall): character plus last, which marks the
// final character of a string (11 bare digits or DDD.DDD.DDD-DD).
// Output channel (rsp_valid / rsp_stall): one verdict per string, valid_res
// and error_code (0 ok, 1 length, 2 bad char, 3 separator or digit count,
// 4 repeated digits, 5 first check, 6 second check).
// Throughput: one character per cycle, set by the single accumulate stage,
// except while a final character waits for a stalled result register. The
// verdict passes the input register, then the result register, before it
// is presented.
// Reset clears the pipeline valids and the per-string counters; the state is
// cleared again after each final character.
// When the receiver stalls, the verdict holds; the input register keeps taking
// non-final characters, and a final character waits until the result register
// frees, which then stalls the input channel.
// ----------------------------------------------------------------------------
module cpf_check_digit_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] character,
  input  logic       last,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic       valid_res,
  output logic [2:0] error_code
);

  logic             s1_valid;
  logic [7:0]       s1_char;
  logic             s1_last;
  logic             advance;
  logic             out_free;
  cpf_pkg::result_t result;

  assign advance = s1_valid && (!s1_last || out_free);

  cpf_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .character (character),
    .last      (last),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_char   (s1_char),
    .s1_last   (s1_last)
  );

  cpf_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ch      (s1_char),
    .last    (s1_last),
    .result  (result)
  );

  cpf_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && s1_last),
    .result     (result),
    .out_free   (out_free),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .valid_res  (valid_res),
    .error_code (error_code)
  );

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(s1_valid && s1_last))
    else $error("verdict without a final character");

  a_flag_matches_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (valid_res == (error_code == cpf_pkg::ERR_NONE)))
    else $error("valid flag disagrees with error code");

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && rsp_valid && rsp_stall) |=> s1_valid && s1_last)
    else $error("final character dropped while result stalled");
`endif

endmodule
